@@ design/bfa_pkg.sv @@
// Shared constants and codes for the bitmap frame allocator.
package bfa_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RESERVE = 2'd2,
    ACT_QUERY   = 2'd3
  } action_t;

  // Field widths of the item payloads
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned ADDR_W  = 36;
  localparam int unsigned SIZE_W  = 37;
  localparam int unsigned LIMIT_W = 17;
  localparam int unsigned RESV_W  = 24;

  // Frame geometry: 4 KiB frames
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned FNUM_W      = ADDR_W - FRAME_SHIFT;   // 24
  localparam int unsigned FCMP_W      = FNUM_W + 1;             // 25

  // Register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LIMIT = 3'd0;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = 17'd65536;

endpackage

@@ design/bfa_bitmap.sv @@
// Used-bit store: one write port and one registered read port.
module bfa_bitmap #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned NWORDS    = 1024,
  parameter int unsigned AW        = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rdata_r;

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/bitmap_frame_allocator_unit.sv @@
// Bitmap frame allocator: request sequencer, counters and stream/APB ports.
// Path from input accept to out_tvalid: decode, then for free and query of a valid frame a
// read and check; rejected requests go straight to the result; reserve and allocate mark
// their frames word by word (read, load, mark, write back), allocate after a frame search.
// One item at a time: in_tready is high only while idle, and a result still held in the
// output register delays the return to idle.
// After reset a clearing pass writes FRAMES/WORD_BITS words and no item is taken
// meanwhile; configuration writes are taken throughout.
module bitmap_frame_allocator_unit #(
  parameter int unsigned FRAMES    = 65536,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [95:0]                       in_tdata,   // count[16:0], address[52:17], size[89:53]
  input  logic [1:0]                        in_tuser,   // action[1:0]
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [79:0]                       out_tdata,  // alloc_address[35:0], status[36],
                                                        // available[37], free_count[54:38],
                                                        // reserved_frames[78:55]
  // configuration
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bfa_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int unsigned NWORDS = FRAMES / WORD_BITS;
  localparam int unsigned BW     = $clog2(WORD_BITS);
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned FW     = $clog2(FRAMES) + 1;
  localparam int unsigned RUN_W  = bfa_pkg::COUNT_W + 1;
  localparam int unsigned SUM_W  = bfa_pkg::SIZE_W + 2;
  localparam int unsigned EF_W   = SUM_W - bfa_pkg::FRAME_SHIFT;
  localparam int unsigned RSUM_W = EF_W + 1;
  localparam logic [bfa_pkg::FCMP_W-1:0] FRAMES_C = bfa_pkg::FCMP_W'(FRAMES);
  localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);
  localparam logic [bfa_pkg::RESV_W-1:0] RESV_MAX = '1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_SRD, S_SBIT, S_MRD, S_MLD, S_MBIT, S_MWR,
    S_FRD, S_FCHK, S_DONE
  } state_t;

  state_t                        state_r;
  logic [1:0]                    act_r;
  logic [bfa_pkg::COUNT_W-1:0]   cnt_r;
  logic [bfa_pkg::ADDR_W-1:0]    addr_r;
  logic [bfa_pkg::SIZE_W-1:0]    size_r;
  logic [FW-1:0]                 f_r;
  logic [FW-1:0]                 end_r;
  logic [RUN_W-1:0]              run_r;
  logic [WORD_BITS-1:0]          wk_r;
  logic [AW-1:0]                 wdx_r;
  logic [FW-1:0]                 used_r;
  logic [bfa_pkg::RESV_W-1:0]    resv_r;
  logic [bfa_pkg::LIMIT_W-1:0]   limit_r;
  logic [bfa_pkg::ADDR_W-1:0]    res_addr_r;
  logic                          res_st_r;
  logic                          res_av_r;
  logic                          out_valid_r;
  logic [79:0]                   out_data_r;

  logic                          mem_we;
  logic [AW-1:0]                 mem_wa;
  logic [WORD_BITS-1:0]          mem_wd;
  logic [WORD_BITS-1:0]          mem_rd;
  logic [AW-1:0]                 f_word;
  logic [BW-1:0]                 f_bit;
  logic [FW-1:0]                 f_inc;
  logic                          f_bit_now;
  logic [bfa_pkg::FCMP_W-1:0]    lim;
  logic [FW-1:0]                 lim_f;
  logic [bfa_pkg::FNUM_W-1:0]    a_frame;
  logic                          frame_ok;
  logic [SUM_W-1:0]              s_sum;
  logic [SUM_W-1:0]              e_sum;
  logic [EF_W-1:0]               sf;
  logic [EF_W-1:0]               ef;
  logic [RSUM_W-1:0]             resv_sum;
  logic [FW-1:0]                 free_diff;
  logic                          cfg_wr;

  // Effective limit: capped at capacity
  always_comb begin
    if ({{(bfa_pkg::FCMP_W - bfa_pkg::LIMIT_W){1'b0}}, limit_r} > FRAMES_C) begin
      lim = FRAMES_C;
    end else begin
      lim = {{(bfa_pkg::FCMP_W - bfa_pkg::LIMIT_W){1'b0}}, limit_r};
    end
  end
  assign lim_f = FW'(lim);

  // Frame position split into word and bit
  assign f_word    = AW'(f_r >> BW);
  assign f_bit     = f_r[BW-1:0];
  assign f_inc     = f_r + FW'(1);
  assign f_bit_now = mem_rd[f_bit];

  // Address checks for free and query
  assign a_frame  = addr_r[bfa_pkg::ADDR_W-1:bfa_pkg::FRAME_SHIFT];
  assign frame_ok = (addr_r != '0) && (addr_r[bfa_pkg::FRAME_SHIFT-1:0] == '0) &&
                    ({1'b0, a_frame} < lim);

  // Reserve range rounded up to frame boundaries
  assign s_sum    = SUM_W'(addr_r) + SUM_W'(12'hFFF);
  assign e_sum    = SUM_W'(addr_r) + SUM_W'(size_r) + SUM_W'(12'hFFF);
  assign sf       = EF_W'(s_sum >> bfa_pkg::FRAME_SHIFT);
  assign ef       = EF_W'(e_sum >> bfa_pkg::FRAME_SHIFT);
  assign resv_sum = RSUM_W'(resv_r) + RSUM_W'(ef - sf);

  assign free_diff = (lim_f > used_r) ? (lim_f - used_r) : '0;

  // Bitmap write port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wdx_r;
    mem_wd = wk_r;
    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
      S_MWR: begin
        mem_we = 1'b1;
      end
      S_FCHK: begin
        mem_we = (act_r == bfa_pkg::ACT_FREE) && f_bit_now;
        mem_wa = f_word;
        mem_wd = mem_rd & ~(WORD_BITS'(1) << f_bit);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  bfa_bitmap #(
    .WORD_BITS (WORD_BITS),
    .NWORDS    (NWORDS),
    .AW        (AW)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (f_word),
    .rdata (mem_rd)
  );

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      wdx_r       <= '0;
      used_r      <= '0;
      resv_r      <= '0;
      limit_r     <= bfa_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_paddr == bfa_pkg::REG_FRAME_LIMIT)) begin
        limit_r <= cfg_pwdata[bfa_pkg::LIMIT_W-1:0];
      end
      // drop a taken result unless a new one replaces it
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        // sweep every word to zero
        S_CLR: begin
          wdx_r <= wdx_r + AW'(1);
          if (wdx_r == LAST_WORD) begin
            state_r <= S_IDLE;
          end
        end
        // take one item
        S_IDLE: begin
          if (in_tvalid) begin
            act_r   <= in_tuser;
            cnt_r   <= in_tdata[16:0];
            addr_r  <= in_tdata[52:17];
            size_r  <= in_tdata[89:53];
            state_r <= S_DEC;
          end
        end
        // decode the request and set up the walk
        S_DEC: begin
          res_addr_r <= '0;
          res_av_r   <= 1'b0;
          unique case (act_r)
            bfa_pkg::ACT_ALLOC: begin
              f_r      <= FW'(1);
              run_r    <= '0;
              res_st_r <= (cnt_r == '0);
              if (cnt_r == '0) begin
                state_r <= S_DONE;
              end else begin
                state_r <= S_SRD;
              end
            end
            bfa_pkg::ACT_RESERVE: begin
              f_r   <= FW'(sf);
              end_r <= FW'(ef);
              if ((size_r == '0) || (ef > EF_W'(FRAMES))) begin
                res_st_r <= 1'b1;
                state_r  <= S_DONE;
              end else begin
                res_st_r <= 1'b0;
                resv_r   <= (resv_sum > RSUM_W'(RESV_MAX)) ? RESV_MAX
                                                           : bfa_pkg::RESV_W'(resv_sum);
                state_r  <= (sf == ef) ? S_DONE : S_MRD;
              end
            end
            default: begin
              f_r <= FW'(a_frame);
              if (frame_ok) begin
                res_st_r <= 1'b0;
                state_r  <= S_FRD;
              end else begin
                res_st_r <= (act_r == bfa_pkg::ACT_FREE);
                state_r  <= S_DONE;
              end
            end
          endcase
        end
        // fetch the word under the search position
        S_SRD: begin
          if (f_r >= lim_f) begin
            res_st_r <= 1'b1;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_SBIT;
          end
        end
        // test one frame of the search
        S_SBIT: begin
          if (f_r >= lim_f) begin
            res_st_r <= 1'b1;
            state_r  <= S_DONE;
          end else if (f_bit_now) begin
            run_r <= '0;
            f_r   <= f_inc;
            if (f_inc[BW-1:0] == '0) begin
              state_r <= S_SRD;
            end
          end else if ((run_r + RUN_W'(1)) == RUN_W'(cnt_r)) begin
            f_r        <= f_inc - FW'(cnt_r);
            end_r      <= f_inc;
            res_addr_r <= bfa_pkg::ADDR_W'(f_inc - FW'(cnt_r)) << bfa_pkg::FRAME_SHIFT;
            state_r    <= S_MRD;
          end else begin
            run_r <= run_r + RUN_W'(1);
            f_r   <= f_inc;
            if (f_inc[BW-1:0] == '0) begin
              state_r <= S_SRD;
            end
          end
        end
        // fetch a word to mark
        S_MRD: begin
          state_r <= S_MLD;
        end
        S_MLD: begin
          wk_r    <= mem_rd;
          wdx_r   <= f_word;
          state_r <= S_MBIT;
        end
        // mark one frame, counting only frames that were free
        S_MBIT: begin
          if (!wk_r[f_bit]) begin
            wk_r[f_bit] <= 1'b1;
            used_r      <= used_r + FW'(1);
          end
          f_r <= f_inc;
          if ((f_inc == end_r) || (f_inc[BW-1:0] == '0)) begin
            state_r <= S_MWR;
          end
        end
        // write the marked word back
        S_MWR: begin
          state_r <= (f_r == end_r) ? S_DONE : S_MRD;
        end
        S_FRD: begin
          state_r <= S_FCHK;
        end
        // free or query one frame
        S_FCHK: begin
          if (act_r == bfa_pkg::ACT_FREE) begin
            if (f_bit_now) begin
              used_r <= used_r - FW'(1);
            end else begin
              res_st_r <= 1'b1;
            end
          end else begin
            res_av_r <= !f_bit_now;
          end
          state_r <= S_DONE;
        end
        // hand the result to the output register
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {1'b0, resv_r, bfa_pkg::LIMIT_W'(free_diff),
                            res_av_r, res_st_r, res_addr_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == bfa_pkg::REG_FRAME_LIMIT) ? 32'(limit_r) : '0;

endmodule

@@ tb/sv/bitmap_frame_allocator_unit_tb.sv @@
// Testbench for the bitmap frame allocator: table-driven and random requests checked
// against a built-in bitmap predictor.
`timescale 1ns / 100ps

module bitmap_frame_allocator_unit_tb;

  localparam int unsigned NFRAMES = 65536;
  localparam logic [63:0] CAP_BYTES = 64'd65536 * 64'd4096;

  typedef struct {
    bfa_pkg::action_t act;
    logic [16:0]      cnt;
    logic [35:0]      adr;
    logic [36:0]      sz;
  } request_t;

  typedef struct packed {
    logic [35:0] run_addr;
    logic        status;
    logic        avail;
    logic [16:0] free_cnt;
    logic [23:0] resv_cnt;
  } answer_t;

  typedef struct {
    request_t req;
    bit       known;
    answer_t  ans;
  } row_t;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [95:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [79:0] out_tdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [bfa_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  bitmap_frame_allocator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),   // count, address, size
    .in_tuser(in_tuser),   // action
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), // alloc_address, status, available, free_count, reserved_frames
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow state of the allocator
  bit          frame_used [NFRAMES];
  int unsigned used_frames;
  logic [23:0] resv_total;
  logic [16:0] limit_reg;

  answer_t     pending_answers [$];
  int unsigned mismatches;
  int unsigned results_seen;
  row_t        dir_rows [$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic answer_t predict_answer(request_t r);
    answer_t     a;
    logic [63:0] lim, f, run, first, s, e, a64, g;
    a = '{default: '0};
    lim = (limit_reg > NFRAMES) ? 64'(NFRAMES) : 64'(limit_reg);
    a64 = 64'(r.adr);
    case (r.act)
      bfa_pkg::ACT_ALLOC: begin
        a.status = 1'b1;
        run = 0;
        if (r.cnt != 0) begin
          for (f = 1; f < lim; f++) begin
            if (frame_used[f]) begin
              run = 0;
            end else begin
              run++;
              if (run == 64'(r.cnt)) begin
                first = f + 1 - run;
                for (g = first; g <= f; g++) begin
                  frame_used[g] = 1'b1;
                  used_frames++;
                end
                a.run_addr = 36'(first << 12);
                a.status = 1'b0;
                break;
              end
            end
          end
        end
      end
      bfa_pkg::ACT_FREE: begin
        f = a64 >> 12;
        if (a64 != 0 && a64[11:0] == 0 && f < lim && frame_used[f]) begin
          frame_used[f] = 1'b0;
          used_frames--;
        end else begin
          a.status = 1'b1;
        end
      end
      bfa_pkg::ACT_RESERVE: begin
        s = (a64 + 64'd4095) & ~64'd4095;
        e = (a64 + 64'(r.sz) + 64'd4095) & ~64'd4095;
        if (r.sz == 0 || e > CAP_BYTES) begin
          a.status = 1'b1;
        end else begin
          for (f = s >> 12; f < (e >> 12); f++) begin
            if (!frame_used[f]) begin
              frame_used[f] = 1'b1;
              used_frames++;
            end
          end
          if (64'(resv_total) + ((e - s) >> 12) > 64'hFF_FFFF) resv_total = 24'hFF_FFFF;
          else resv_total = resv_total + 24'((e - s) >> 12);
        end
      end
      default: begin
        f = a64 >> 12;
        a.avail = (a64 != 0 && a64[11:0] == 0 && f < lim && !frame_used[f]);
      end
    endcase
    a.free_cnt = (lim > used_frames) ? 17'(lim - used_frames) : '0;
    a.resv_cnt = resv_total;
    return a;
  endfunction

  // Offer one item; hold it until taken
  task automatic offer_item(request_t r, bit known, answer_t typed);
    answer_t a;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = r.act;
    in_tdata  = {6'd0, r.sz, r.adr, r.cnt};
    do @(posedge clk); while (!in_tready);
    a = predict_answer(r);
    pending_answers.push_back(known ? typed : a);
  endtask

  task automatic idle_input(int unsigned cycles);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_paddr = bfa_pkg::REG_FRAME_LIMIT;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    limit_reg = value[16:0];
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  function automatic request_t random_request(int unsigned lim);
    request_t    r;
    int unsigned span, pick;
    span = (lim > 1000) ? 600 : lim;
    r.cnt = 17'($urandom_range(1, 8));
    r.adr = 36'($urandom_range(0, span + 2)) << 12;
    r.sz  = 37'($urandom_range(1, 16384));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.act = bfa_pkg::ACT_ALLOC;
      case ($urandom_range(0, 9))
        0: r.cnt = '0;
        1: if (lim <= 1000) r.cnt = 17'(lim + $urandom_range(0, 2));
        2: if (lim <= 1000) r.cnt = 17'($urandom);
        default: ;
      endcase
    end else if (pick < 65) begin
      r.act = bfa_pkg::ACT_FREE;
    end else if (pick < 75) begin
      r.act = bfa_pkg::ACT_RESERVE;
      case ($urandom_range(0, 29))
        0: r.sz = {5'($urandom), 32'($urandom)};
        1: r.sz = '0;
        2: r.adr = {4'($urandom), 32'($urandom)};
        3, 4: r.adr = r.adr | 36'($urandom_range(1, 4095));
        default: ;
      endcase
    end else begin
      r.act = bfa_pkg::ACT_QUERY;
    end
    // Scramble the address now and then for free and query
    if (r.act == bfa_pkg::ACT_FREE || r.act == bfa_pkg::ACT_QUERY) begin
      case ($urandom_range(0, 9))
        0: r.adr = {4'($urandom), 32'($urandom)};
        1: r.adr = r.adr | 36'($urandom_range(1, 4095));
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic void add_row(bfa_pkg::action_t act, logic [16:0] cnt, logic [35:0] adr,
                                  logic [36:0] sz, bit known, logic [35:0] ra,
                                  logic st, logic av, logic [16:0] fc, logic [23:0] rc);
    row_t w;
    w.req = '{act, cnt, adr, sz};
    w.known = known;
    w.ans = '{ra, st, av, fc, rc};
    dir_rows.push_back(w);
  endfunction

  // Receiver: stall pattern plus one long hold-off
  initial begin
    int unsigned mode, hold, span;
    bit          held_once;
    out_tready = 1'b0;
    held_once = 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (!held_once && results_seen >= 150) begin
        held_once = 1'b1;
        out_tready = 1'b0;
        for (hold = 0; hold < 400; hold++) @(negedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
      end
      span--;
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 1) == 0);
        2: out_tready = ($urandom_range(0, 7) != 0);
        default: out_tready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    answer_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got = '{out_tdata[35:0], out_tdata[36], out_tdata[37], out_tdata[54:38],
              out_tdata[78:55]};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_answers.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d: expected %p got %p",
                                         results_seen, want, got);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned limits [$];
    int unsigned n_items, sent, left, gap;
    request_t    r;
    answer_t     blank;
    blank = '{default: '0};
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0; cfg_paddr = '0; cfg_pwdata = '0;
    mismatches = 0; results_seen = 0;
    used_frames = 0; resv_total = '0; limit_reg = bfa_pkg::LIMIT_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows at the reset limit
    add_row(bfa_pkg::ACT_QUERY,   0, 36'h1000, 0, 1, 0, 0, 1, 65536, 0);
    add_row(bfa_pkg::ACT_ALLOC,   0, 0, 0, 1, 0, 1, 0, 65536, 0);
    add_row(bfa_pkg::ACT_ALLOC,   1, 0, 0, 1, 36'h1000, 0, 0, 65535, 0);
    add_row(bfa_pkg::ACT_ALLOC,   3, 0, 0, 1, 36'h2000, 0, 0, 65532, 0);
    add_row(bfa_pkg::ACT_FREE,    0, 36'h0, 0, 1, 0, 1, 0, 65532, 0);
    add_row(bfa_pkg::ACT_FREE,    0, 36'h2001, 0, 1, 0, 1, 0, 65532, 0);
    add_row(bfa_pkg::ACT_FREE,    0, 36'h2000, 0, 1, 0, 0, 0, 65533, 0);
    add_row(bfa_pkg::ACT_FREE,    0, 36'h2000, 0, 1, 0, 1, 0, 65533, 0);
    add_row(bfa_pkg::ACT_QUERY,   0, 36'h2000, 0, 1, 0, 0, 1, 65533, 0);
    add_row(bfa_pkg::ACT_QUERY,   0, 36'h3000, 0, 1, 0, 0, 0, 65533, 0);
    add_row(bfa_pkg::ACT_QUERY,   0, 36'hF_FFFF_FFFF, 0, 1, 0, 0, 0, 65533, 0);
    add_row(bfa_pkg::ACT_QUERY,   0, 36'h1000_0000, 0, 1, 0, 0, 0, 65533, 0);
    add_row(bfa_pkg::ACT_RESERVE, 0, 36'h5000, 0, 1, 0, 1, 0, 65533, 0);
    add_row(bfa_pkg::ACT_RESERVE, 0, 36'hF_FFFF_FFFF, 37'h1F_FFFF_FFFF, 1, 0, 1, 0, 65533, 0);
    add_row(bfa_pkg::ACT_RESERVE, 0, 36'h0, 37'h1, 1, 0, 0, 0, 65532, 1);
    add_row(bfa_pkg::ACT_RESERVE, 0, 36'hFFF_F000, 37'h1000, 1, 0, 0, 0, 65531, 2);
    add_row(bfa_pkg::ACT_RESERVE, 0, 36'h6001, 37'h2000, 0, 0, 0, 0, 0, 0);
    add_row(bfa_pkg::ACT_ALLOC,   17'h1FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(bfa_pkg::ACT_ALLOC,   17'd65536, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(bfa_pkg::ACT_ALLOC,   2, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(bfa_pkg::ACT_FREE,    0, 36'hFFF_F000, 0, 0, 0, 0, 0, 0, 0);
    add_row(bfa_pkg::ACT_RESERVE, 0, 36'h100_0000, 37'h80_0000, 0, 0, 0, 0, 0, 0);
    add_row(bfa_pkg::ACT_QUERY,   0, 36'h1001, 0, 0, 0, 0, 0, 0, 0);
    foreach (dir_rows[i]) offer_item(dir_rows[i].req, dir_rows[i].known, dir_rows[i].ans);
    idle_input(1);
    drain_results();

    // Random phases over a spread of limits, extremes included
    limits = '{0, 1, 2};
    repeat (6) limits.push_back($urandom_range(64, 400));
    limits.push_back(32'h1FFFF);
    sent = 0;
    foreach (limits[p]) begin
      write_limit(limits[p]);
      n_items = (limits[p] <= 2) ? 30 : (limits[p] > 1000 ? 40 : 110);
      left = n_items;
      while (left > 0) begin
        for (int unsigned b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
          r = random_request(limits[p]);
          offer_item(r, 0, blank);
          left--;
          sent++;
          // Pause until the pipeline is empty once
          if (sent == 300) begin
            idle_input(0);
            while (pending_answers.size() != 0) @(negedge clk);
          end
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) idle_input(gap);
      end
      idle_input(0);
      drain_results();
    end

    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ bitmap_frame_allocator_unit.f @@
design/bfa_pkg.sv
design/bfa_bitmap.sv
design/bitmap_frame_allocator_unit.sv
tb/sv/bitmap_frame_allocator_unit_tb.sv
